### rtl/core/mtcg_pkg.sv
// ============================================================================
// mtcg_pkg: shared types and constants of the MIDI time code clock generator
// Action codes, transport events, sync modes and the fixed MIDI byte values.
// ============================================================================
package mtcg_pkg;

  // Default frame rate of the playhead
  localparam int unsigned FpsDefault = 24;

  // Input actions
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_START    = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_CONTINUE = 3'd3,
    ACT_LOCATE   = 3'd4
  } action_e;

  // Pending transport event
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_STOP     = 3'd2,
    EV_CONTINUE = 3'd3,
    EV_LOCATE   = 3'd4
  } event_e;

  // Sync mode register values
  typedef enum logic [1:0] {
    SYNC_NONE  = 2'd0,
    SYNC_CLOCK = 2'd1,
    SYNC_MTC   = 2'd2,
    SYNC_RSVD  = 2'd3
  } sync_e;

  // Message being sent on the output
  typedef enum logic [1:0] {
    MSG_ONE  = 2'd0,
    MSG_QF   = 2'd1,
    MSG_FULL = 2'd2
  } msg_e;

  // MIDI status bytes
  localparam logic [7:0] MidiQuarterFrame = 8'hf1;
  localparam logic [7:0] MidiSongPos      = 8'hf2;
  localparam logic [7:0] MidiClock        = 8'hf8;
  localparam logic [7:0] MidiStart        = 8'hfa;
  localparam logic [7:0] MidiContinue     = 8'hfb;
  localparam logic [7:0] MidiStop         = 8'hfc;
  localparam logic [7:0] MidiSysexEnd     = 8'hf7;

  // Full-frame SysEx header
  localparam int unsigned SysexHeadLen = 5;
  localparam logic [7:0] SysexHead [SysexHeadLen] = '{8'hf0, 8'h7f, 8'h7f, 8'h01, 8'h01};

  // Message lengths, as index of the final byte
  localparam logic [3:0] LastIdxOne  = 4'd0;
  localparam logic [3:0] LastIdxQf   = 4'd1;
  localparam logic [3:0] LastIdxFull = 4'd9;

  // Time limits
  localparam logic [4:0] HoursMax   = 5'd23;
  localparam logic [5:0] MinutesMax = 6'd59;
  localparam logic [5:0] SecondsMax = 6'd59;
  localparam logic [4:0] HoursWrap  = 5'd24;
  localparam logic [5:0] SixtyWrap  = 6'd60;

  // MTC rate code for a frame rate
  function automatic logic [1:0] rate_code(input int unsigned fps);
    logic [1:0] code;
    case (fps)
      25:      code = 2'd1;
      29:      code = 2'd2;
      30:      code = 2'd3;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/midi_timecode_clock_generator_unit.sv
// ============================================================================
// midi_timecode_clock_generator_unit: MTC quarter-frame / MIDI clock master
// Turns transport actions and timer ticks into a stream of MIDI bytes.
// ============================================================================
// An input transfer updates the transport state in the cycle it is taken and,
// for a tick, loads the message it causes into the output stage. Actions that
// send nothing do not occupy the output stage. A message is 1 byte in clock
// mode, 2 for a quarter frame, 10 for a full-frame SysEx, at one byte per
// cycle while out_ready_i is high. The next input is taken in the same cycle
// as the final byte of the previous message, so back-to-back messages leave
// no gap. No clearing pass runs after reset.
module midi_timecode_clock_generator_unit
  import mtcg_pkg::*;
#(
  parameter int unsigned FramesPerSecond = FpsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [4:0] hours_i,
  input  logic [5:0] minutes_i,
  input  logic [5:0] seconds_i,
  input  logic [4:0] frames_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] midi_byte_o,
  output logic       last_byte_o
);

  localparam logic [4:0] FrameMax  = 5'(FramesPerSecond - 1);
  localparam logic [5:0] FrameWrap = 6'(FramesPerSecond);
  localparam logic [1:0] RateCode  = rate_code(FramesPerSecond);

  // Transport state
  sync_e      sync_q;
  event_e     pend_q, pend_d;
  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic [4:0] frames_q, frames_d;
  logic [2:0] qidx_q, qidx_d;

  // Output stage
  logic       busy_q, busy_d;
  msg_e       kind_q, kind_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] ba_q, ba_d;      // single byte, quarter-frame byte or hours byte
  logic [5:0] bmin_q, bmin_d;
  logic [5:0] bsec_q, bsec_d;
  logic [4:0] bfrm_q, bfrm_d;

  logic       in_xfer, out_xfer, is_last;
  logic [3:0] last_idx;

  // Tick helpers
  logic [4:0] eh;
  logic [5:0] em, es;
  logic [4:0] ef;
  logic [3:0] nib;
  logic [5:0] fsum;
  logic [5:0] sec_inc, min_inc;
  logic [4:0] hr_inc;
  logic       c_sec, c_min, c_hr;
  logic [2:0] qnext;
  logic       emit;

  // Handshake
  always_comb begin
    case (kind_q)
      MSG_QF:   last_idx = LastIdxQf;
      MSG_FULL: last_idx = LastIdxFull;
      default:  last_idx = LastIdxOne;
    endcase
  end

  assign is_last     = (idx_q == last_idx);
  assign out_valid_o = busy_q;
  assign out_xfer    = busy_q & out_ready_i;
  assign in_ready_o  = ~busy_q | (out_ready_i & is_last);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign last_byte_o = is_last;

  // Byte select for the current position in the message
  always_comb begin
    midi_byte_o = ba_q;
    case (kind_q)
      MSG_QF:   midi_byte_o = (idx_q == 4'd0) ? MidiQuarterFrame : ba_q;
      MSG_FULL: begin
        case (idx_q)
          4'd0, 4'd1, 4'd2, 4'd3, 4'd4: midi_byte_o = SysexHead[3'(idx_q)];
          4'd5:    midi_byte_o = ba_q;
          4'd6:    midi_byte_o = {2'b00, bmin_q};
          4'd7:    midi_byte_o = {2'b00, bsec_q};
          4'd8:    midi_byte_o = {3'b000, bfrm_q};
          default: midi_byte_o = MidiSysexEnd;
        endcase
      end
      default:  midi_byte_o = ba_q;
    endcase
  end

  // Quarter-frame playhead: cleared when a start is pending
  always_comb begin
    if (pend_q == EV_START) begin
      eh = '0; em = '0; es = '0; ef = '0;
    end else begin
      eh = hours_q; em = minutes_q; es = seconds_q; ef = frames_q;
    end
  end

  // Quarter-frame nibble
  always_comb begin
    case ((pend_q == EV_START) ? 3'd0 : qidx_q)
      3'd0:    nib = ef[3:0];
      3'd1:    nib = {3'b000, ef[4]};
      3'd2:    nib = es[3:0];
      3'd3:    nib = {2'b00, es[5:4]};
      3'd4:    nib = em[3:0];
      3'd5:    nib = {2'b00, em[5:4]};
      3'd6:    nib = eh[3:0];
      default: nib = {1'b0, RateCode, eh[4]};
    endcase
  end

  // Two-frame advance with carries
  always_comb begin
    fsum    = {1'b0, ef} + 6'd2;
    c_sec   = (fsum >= FrameWrap);
    sec_inc = es + {5'd0, c_sec};
    c_min   = (sec_inc >= SixtyWrap);
    min_inc = em + {5'd0, c_min};
    c_hr    = (min_inc >= SixtyWrap);
    hr_inc  = eh + {4'd0, c_hr};
  end

  assign qnext = ((pend_q == EV_START) ? 3'd0 : qidx_q) + 3'd1;

  // Transport next state and message load
  always_comb begin
    pend_d    = pend_q;
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    frames_d  = frames_q;
    qidx_d    = qidx_q;
    emit      = 1'b0;
    kind_d    = kind_q;
    ba_d      = ba_q;
    bmin_d    = bmin_q;
    bsec_d    = bsec_q;
    bfrm_d    = bfrm_q;
    if (in_xfer) begin
      case (action_e'(action_i))
        ACT_TICK: begin
          if (sync_q == SYNC_MTC) begin
            if (pend_q == EV_LOCATE) begin
              emit   = 1'b1;
              kind_d = MSG_FULL;
              ba_d   = {1'b0, RateCode, hours_q};
              bmin_d = minutes_q;
              bsec_d = seconds_q;
              bfrm_d = frames_q;
              pend_d = EV_STOP;
            end else if (pend_q != EV_STOP) begin
              emit   = 1'b1;
              kind_d = MSG_QF;
              ba_d   = {1'b0, ((pend_q == EV_START) ? 3'd0 : qidx_q), nib};
              if (pend_q == EV_START) pend_d = EV_CONTINUE;
              qidx_d    = qnext;
              hours_d   = eh;
              minutes_d = em;
              seconds_d = es;
              frames_d  = ef;
              if (qnext == 3'd0) begin
                frames_d  = c_sec ? 5'(fsum - FrameWrap) : fsum[4:0];
                seconds_d = c_min ? 6'd0 : sec_inc;
                minutes_d = c_hr ? 6'd0 : min_inc;
                hours_d   = (hr_inc >= HoursWrap) ? 5'd0 : hr_inc;
              end
            end
          end else if (sync_q == SYNC_CLOCK) begin
            emit   = 1'b1;
            kind_d = MSG_ONE;
            case (pend_q)
              EV_START:    ba_d = MidiStart;
              EV_STOP:     ba_d = MidiStop;
              EV_CONTINUE: ba_d = MidiContinue;
              EV_LOCATE:   ba_d = MidiSongPos;
              default:     ba_d = MidiClock;
            endcase
            pend_d = EV_NONE;
          end
        end
        ACT_START:    pend_d = EV_START;
        ACT_STOP:     pend_d = EV_STOP;
        ACT_CONTINUE: pend_d = EV_CONTINUE;
        ACT_LOCATE: begin
          hours_d   = (hours_i > HoursMax) ? HoursMax : hours_i;
          minutes_d = (minutes_i > MinutesMax) ? MinutesMax : minutes_i;
          seconds_d = (seconds_i > SecondsMax) ? SecondsMax : seconds_i;
          frames_d  = (frames_i > FrameMax) ? FrameMax : frames_i;
          qidx_d    = '0;
          if (sync_q == SYNC_MTC) pend_d = EV_LOCATE;
        end
        default: ;
      endcase
    end
  end

  // Output sequencer
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (out_xfer) begin
      if (is_last) busy_d = 1'b0;
      else idx_d = idx_q + 4'd1;
    end
    if (emit) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q    <= SYNC_NONE;
      pend_q    <= EV_NONE;
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
      frames_q  <= '0;
      qidx_q    <= '0;
      busy_q    <= 1'b0;
      idx_q     <= '0;
      kind_q    <= MSG_ONE;
    end else begin
      if (cfg_we_i) sync_q <= sync_e'(cfg_wdata_i);
      pend_q    <= pend_d;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      frames_q  <= frames_d;
      qidx_q    <= qidx_d;
      busy_q    <= busy_d;
      idx_q     <= idx_d;
      kind_q    <= kind_d;
    end
  end

  // Message payload
  always_ff @(posedge clk_i) begin
    ba_q   <= ba_d;
    bmin_q <= bmin_d;
    bsec_q <= bsec_d;
    bfrm_q <= bfrm_d;
  end

endmodule

### rtl/core/mtcg_checker.sv
// ============================================================================
// mtcg_checker: port-level checks for the MIDI time code clock generator
// Watches the handshakes and the message framing seen at the top level.
// ============================================================================
module mtcg_checker
  import mtcg_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [2:0] action_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] midi_byte_o,
  input logic       last_byte_o
);

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(midi_byte_o) && $stable(last_byte_o))
    else $error("stalled output changed");

  // Input is held off only while a result waits
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  // A message continues after a byte that is not its last
  a_msg_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_byte_o |=> out_valid_o)
    else $error("message cut short");

  // Output goes quiet after a final byte unless a new item came in
  a_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && last_byte_o && !in_xfer |=> !out_valid_o)
    else $error("byte appeared without a cause");

  // Transport actions send nothing
  a_action_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (action_i != ACT_TICK) && !out_valid_o |=> !out_valid_o)
    else $error("transport action produced output");

endmodule

bind midi_timecode_clock_generator_unit mtcg_checker u_mtcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .midi_byte_o (midi_byte_o),
  .last_byte_o (last_byte_o)
);
